/* hdl/cdcw_pkg.sv */
// Package for the date check and weekday block: transaction types, constants, lookup functions.
`default_nettype none

package cdcw_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned BASE_YEAR_DEF = 1800;
  localparam int unsigned MAX_YEAR_DEF  = 9999;

  // Field widths
  localparam int DayW   = 5;
  localparam int MonW   = 4;
  localparam int YearW  = 14;
  localparam int MdaysW = 5;
  localparam int WdayW  = 3;

  // Division by 25 through a reciprocal: q = (x * RECIP25) >> RECIP_SH.
  // Exact for x below 2^17 / 3, far above the 12-bit operands used here.
  localparam logic [12:0] RECIP25  = 13'd5243;
  localparam int          RECIP_SH = 17;

  // Month numbers used by name
  localparam logic [MonW-1:0] MON_JAN = 4'd1;
  localparam logic [MonW-1:0] MON_FEB = 4'd2;
  localparam logic [MonW-1:0] MON_DEC = 4'd12;

  // Input transaction
  typedef struct packed {
    logic [DayW-1:0]  day;
    logic [MonW-1:0]  month;
    logic [YearW-1:0] year;
  } cdcw_in_t;

  // Result transaction
  typedef struct packed {
    logic              valid_res;
    logic              leap;
    logic [MdaysW-1:0] month_days;
    logic [WdayW-1:0]  weekday;
  } cdcw_out_t;

  // Days in a month; 0 for a month number outside 1..12
  function automatic logic [MdaysW-1:0] month_len(input logic [MonW-1:0] m, input logic lp);
    logic [MdaysW-1:0] r;
    begin
      unique case (m)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
        4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
        4'd2:                                       r = lp ? 5'd29 : 5'd28;
        default:                                    r = 5'd0;
      endcase
      return r;
    end
  endfunction

  // Days before the first of the month in a common year, modulo 7
  function automatic logic [2:0] month_off7(input logic [MonW-1:0] m);
    logic [2:0] r;
    begin
      unique case (m)
        4'd1:    r = 3'd0;
        4'd2:    r = 3'd3;
        4'd3:    r = 3'd3;
        4'd4:    r = 3'd6;
        4'd5:    r = 3'd1;
        4'd6:    r = 3'd4;
        4'd7:    r = 3'd6;
        4'd8:    r = 3'd2;
        4'd9:    r = 3'd5;
        4'd10:   r = 3'd0;
        4'd11:   r = 3'd3;
        4'd12:   r = 3'd5;
        default: r = 3'd0;
      endcase
      return r;
    end
  endfunction

  // Residue modulo 7 of a 15-bit value: 8 == 1 (mod 7), so fold 3-bit digits
  function automatic logic [2:0] mod7(input logic [14:0] v);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [3:0] s3;
    begin
      s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12]);
      s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
      s3 = (s2 >= 4'd7) ? s2 - 4'd7 : s2;
      return 3'(s3);
    end
  endfunction

endpackage

`default_nettype wire

/* hdl/calendar_date_check_and_weekday_top.sv */
// Top level: Gregorian date check, leap flag, month length and weekday, four-stage pipeline.
//
//  channel | signals                          | direction | content
//  --------+----------------------------------+-----------+-------------------------------
//  in      | in_valid, in_stall, in_data      | to block  | day, month, year
//  out     | out_valid, out_stall, out_data   | from block| valid_res, leap, month_days, weekday
//
// One transaction per cycle while out_stall is low; each result is registered in stages 1 to 4.
// The four register stages are: reciprocal multiplies, leap-year sum,
// leap and month decode with a mod-7 fold, then the final weekday sum.
// Reset (rst, synchronous) clears the stage valid bits; payload registers are not reset.
// A stalled output holds its stage; each stage still fills while it is empty, so
// in_stall rises only when every stage holds a transaction.
`default_nettype none

module calendar_date_check_and_weekday_top #(
  parameter int unsigned BASE_YEAR = cdcw_pkg::BASE_YEAR_DEF,
  parameter int unsigned MAX_YEAR  = cdcw_pkg::MAX_YEAR_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire cdcw_pkg::cdcw_in_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output cdcw_pkg::cdcw_out_t     out_data
);

  localparam logic [16:0] BaseYr = 17'(BASE_YEAR);
  localparam logic [16:0] MaxYr  = 17'(MAX_YEAR);

  // Stage valid bits and per-stage load enables
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !v4 || !out_stall;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // Stage 1: prior-year count, reciprocal products for py/100 and py/400, range flag
  cdcw_pkg::cdcw_in_t s1_item;
  logic [13:0]        s1_py;
  logic [24:0]        s1_p100;
  logic [22:0]        s1_p400;
  logic               s1_rng;
  logic [13:0]        py_c;

  assign py_c = in_data.year - 14'd1;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_item <= in_data;
      s1_py   <= py_c;
      s1_p100 <= 25'(py_c[13:2]) * 25'(cdcw_pkg::RECIP25);
      s1_p400 <= 23'(py_c[13:4]) * 23'(cdcw_pkg::RECIP25);
      s1_rng  <= (17'(in_data.year) >= BaseYr) && (17'(in_data.year) <= MaxYr);
    end
  end

  // Stage 2: py + py/4 - py/100 + py/400 (365 == 1 mod 7); products for year/100, year/400
  logic [4:0]  s2_day;
  logic [3:0]  s2_month;
  logic [13:0] s2_year;
  logic        s2_rng;
  logic [14:0] s2_sum;
  logic [24:0] s2_y100;
  logic [22:0] s2_y400;
  logic [7:0]  q100_c;
  logic [5:0]  q400_c;

  assign q100_c = s1_p100[24:cdcw_pkg::RECIP_SH];
  assign q400_c = s1_p400[22:cdcw_pkg::RECIP_SH];

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_day   <= s1_item.day;
      s2_month <= s1_item.month;
      s2_year  <= s1_item.year;
      s2_rng   <= s1_rng;
      s2_sum   <= 15'(s1_py) + 15'(s1_py[13:2]) - 15'(q100_c) + 15'(q400_c);
      s2_y100  <= 25'(s1_item.year[13:2]) * 25'(cdcw_pkg::RECIP25);
      s2_y400  <= 23'(s1_item.year[13:4]) * 23'(cdcw_pkg::RECIP25);
    end
  end

  // Stage 3: leap rule, month length, year-count residue mod 7
  logic [4:0]  s3_day;
  logic [3:0]  s3_month;
  logic        s3_rng;
  logic        s3_ypos;
  logic        s3_leap;
  logic [4:0]  s3_mdays;
  logic [2:0]  s3_r7;
  logic [7:0]  yq100_c;
  logic [5:0]  yq400_c;
  logic        z100_c, z400_c, leap_c;

  assign yq100_c = s2_y100[24:cdcw_pkg::RECIP_SH];
  assign yq400_c = s2_y400[22:cdcw_pkg::RECIP_SH];
  assign z100_c  = (s2_year[1:0] == 2'd0) && (s2_year[13:2] == 12'(yq100_c) * 12'd25);
  assign z400_c  = (s2_year[3:0] == 4'd0) && (s2_year[13:4] == 10'(yq400_c) * 10'd25);
  assign leap_c  = z100_c ? z400_c : (s2_year[1:0] == 2'd0);

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_day   <= s2_day;
      s3_month <= s2_month;
      s3_rng   <= s2_rng;
      s3_ypos  <= (s2_year != 14'd0);
      s3_leap  <= leap_c;
      s3_mdays <= cdcw_pkg::month_len(s2_month, leap_c);
      s3_r7    <= cdcw_pkg::mod7(s2_sum);
    end
  end

  // Stage 4: validity and weekday from the residue, month offset and day
  logic       ok_c;
  logic       feb29_c;
  logic [5:0] tot_c;
  logic [2:0] wd_c;

  assign ok_c    = s3_ypos && (s3_mdays != 5'd0) && (s3_day != 5'd0) && (s3_day <= s3_mdays);
  assign feb29_c = s3_leap && (s3_month > cdcw_pkg::MON_FEB);
  assign tot_c   = 6'(s3_r7) + 6'(cdcw_pkg::month_off7(s3_month)) + 6'(feb29_c)
                 + 6'(s3_day) - 6'd1;
  assign wd_c    = (ok_c && s3_rng) ? cdcw_pkg::mod7(15'(tot_c)) + 3'd1 : 3'd0;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      out_data.valid_res  <= ok_c;
      out_data.leap       <= s3_leap;
      out_data.month_days <= s3_mdays;
      out_data.weekday    <= wd_c;
    end
  end

  assign out_valid = v4;

  // Checks
  a_take_fills_s1: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> v1)
    else $error("accepted transaction did not enter stage 1");

  a_wday_needs_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.weekday != 3'd0) |-> out_data.valid_res)
    else $error("weekday given for an invalid date");

  a_bad_month_invalid: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.month_days == 5'd0)
      |-> !out_data.valid_res && (out_data.weekday == 3'd0))
    else $error("bad month reported as valid");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> v1 && v2 && v3 && v4 && out_stall)
    else $error("input stalled with a free stage");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Testbench for the date check and weekday block: queued driver, checking monitor, date predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int RANDOM_N   = 750;
  localparam int SETTLE_CYC = 12;

  // Common-year month lengths, indexed by month number
  localparam int unsigned COMMON_LEN [0:12] =
    '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  cdcw_pkg::cdcw_in_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  cdcw_pkg::cdcw_out_t out_data;

  cdcw_pkg::cdcw_in_t  pending_dates [$];
  cdcw_pkg::cdcw_out_t expected_results [$];
  int        accepted_cnt = 0;
  int        directed_total = 0;
  int        err_count = 0;
  int        gap_left = 0;
  int        stall_left = 0;
  bit        drain_wait = 1'b0;
  bit        quiet = 1'b0;

  calendar_date_check_and_weekday_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // Gregorian leap rule
  function automatic bit is_gregorian_leap(input int unsigned y);
    if (y % 100 == 0) return (y % 400 == 0);
    return (y % 4 == 0);
  endfunction

  // Days in a month; 0 outside January..December
  function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
    if (m < cdcw_pkg::MON_JAN || m > cdcw_pkg::MON_DEC) return 0;
    if (m == cdcw_pkg::MON_FEB && is_gregorian_leap(y)) return 29;
    return COMMON_LEN[m];
  endfunction

  // Expected result for one date
  function automatic cdcw_pkg::cdcw_out_t predict_result(input cdcw_pkg::cdcw_in_t dt);
    cdcw_pkg::cdcw_out_t r;
    int unsigned d;
    int unsigned m;
    int unsigned y;
    int unsigned py;
    int unsigned mlen;
    int unsigned day_count;
    bit          ok;
    d    = dt.day;
    m    = dt.month;
    y    = dt.year;
    mlen = days_in_month(m, y);
    ok   = (y > 0) && (mlen != 0) && (d >= 1) && (d <= mlen);
    r.valid_res  = ok;
    r.leap       = is_gregorian_leap(y);
    r.month_days = cdcw_pkg::MdaysW'(mlen);
    r.weekday    = '0;
    // Day count from 1 Jan of year 1, a Monday
    if (ok && y >= cdcw_pkg::BASE_YEAR_DEF && y <= cdcw_pkg::MAX_YEAR_DEF) begin
      py = y - 1;
      day_count = py * 365 + py / 4 - py / 100 + py / 400;
      for (int unsigned i = cdcw_pkg::MON_JAN; i < m; i++) day_count += days_in_month(i, y);
      day_count += d - 1;
      r.weekday = cdcw_pkg::WdayW'(day_count % 7 + 1);
    end
    return r;
  endfunction

  function automatic cdcw_pkg::cdcw_in_t make_date(input int unsigned d, input int unsigned m,
                                                   input int unsigned y);
    cdcw_pkg::cdcw_in_t t;
    t.day   = cdcw_pkg::DayW'(d);
    t.month = cdcw_pkg::MonW'(m);
    t.year  = cdcw_pkg::YearW'(y);
    return t;
  endfunction

  // Idle run length: mostly short, sometimes medium, rarely long
  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Random date: mostly real dates, some near misses, some raw noise
  function automatic cdcw_pkg::cdcw_in_t random_date();
    int unsigned y;
    int unsigned m;
    int unsigned mlen;
    int          r;
    int          k;
    r = $urandom_range(0, 99);
    if (r < 15) return make_date($urandom_range(0, 31), $urandom_range(0, 15),
                                 $urandom_range(0, 9999));
    k = $urandom_range(0, 99);
    if (k < 55)      y = $urandom_range(cdcw_pkg::BASE_YEAR_DEF, cdcw_pkg::MAX_YEAR_DEF);
    else if (k < 70) y = $urandom_range(1, cdcw_pkg::BASE_YEAR_DEF - 1);
    else if (k < 85) y = $urandom_range(16, 99) * 100;
    else             y = $urandom_range(450, 2499) * 4;
    m = ($urandom_range(0, 4) == 0) ? cdcw_pkg::MON_FEB
                                    : $urandom_range(cdcw_pkg::MON_JAN, cdcw_pkg::MON_DEC);
    mlen = days_in_month(m, y);
    // Broken sequence: one day past the end, or day zero
    if (r < 30) return make_date(($urandom_range(0, 1) != 0) ? mlen + 1 : 0, m, y);
    k = $urandom_range(0, 9);
    if (k < 2) return make_date(mlen, m, y);
    if (k < 3) return make_date(1, m, y);
    return make_date($urandom_range(1, mlen), m, y);
  endfunction

  // Driver: presents queued dates, random gaps, drains at two points
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_result(in_data));
        accepted_cnt++;
        if (accepted_cnt == directed_total || accepted_cnt == directed_total + RANDOM_N / 2)
          drain_wait = 1'b1;
        if (accepted_cnt % 80 == 0) quiet = ($urandom_range(0, 3) == 0);
      end
      if (!in_valid || !in_stall) begin
        if (drain_wait && expected_results.size() == 0) drain_wait = 1'b0;
        if (drain_wait || pending_dates.size() == 0) begin
          in_valid <= 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else begin
          in_data  <= pending_dates.pop_front();
          in_valid <= 1'b1;
          gap_left = (quiet || $urandom_range(0, 1) == 0) ? 0 : pick_idle_len();
        end
      end
    end
  end

  // Monitor: random stall runs, compares each result with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction: %p", out_data);
          err_count++;
        end else begin
          cdcw_pkg::cdcw_out_t exp_r;
          exp_r = expected_results.pop_front();
          if (out_data.valid_res !== exp_r.valid_res) begin
            $error("valid_res: expected %0d, got %0d", exp_r.valid_res, out_data.valid_res);
            err_count++;
          end
          if (out_data.leap !== exp_r.leap) begin
            $error("leap: expected %0d, got %0d", exp_r.leap, out_data.leap);
            err_count++;
          end
          if (out_data.month_days !== exp_r.month_days) begin
            $error("month_days: expected %0d, got %0d", exp_r.month_days, out_data.month_days);
            err_count++;
          end
          if (out_data.weekday !== exp_r.weekday) begin
            $error("weekday: expected %0d, got %0d", exp_r.weekday, out_data.weekday);
            err_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!quiet && $urandom_range(0, 3) == 0) stall_left = pick_idle_len();
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    // Extremes and special cases
    pending_dates.push_back(make_date(0, 0, 0));
    pending_dates.push_back(make_date(31, 15, 16383));
    pending_dates.push_back(make_date(1, 1, 1));
    pending_dates.push_back(make_date(31, 12, 9999));
    pending_dates.push_back(make_date(1, 1, 1800));
    pending_dates.push_back(make_date(31, 12, 1799));
    pending_dates.push_back(make_date(29, cdcw_pkg::MON_FEB, 2000));
    pending_dates.push_back(make_date(29, cdcw_pkg::MON_FEB, 1900));
    pending_dates.push_back(make_date(28, cdcw_pkg::MON_FEB, 1900));
    pending_dates.push_back(make_date(29, cdcw_pkg::MON_FEB, 2024));
    pending_dates.push_back(make_date(29, cdcw_pkg::MON_FEB, 2023));
    pending_dates.push_back(make_date(0, 5, 2010));
    pending_dates.push_back(make_date(31, 4, 2010));
    pending_dates.push_back(make_date(30, 4, 2010));
    pending_dates.push_back(make_date(10, 0, 2010));
    pending_dates.push_back(make_date(10, 13, 2010));
    pending_dates.push_back(make_date(10, 15, 2010));
    pending_dates.push_back(make_date(1, 1, 0));
    pending_dates.push_back(make_date(29, cdcw_pkg::MON_FEB, 0));
    pending_dates.push_back(make_date(1, 1, 10000));
    pending_dates.push_back(make_date(31, 12, 16383));
    pending_dates.push_back(make_date(31, 1, 2024));
    pending_dates.push_back(make_date(1, 3, 2400));
    pending_dates.push_back(make_date(15, 8, 1947));
    directed_total = pending_dates.size();
    for (int i = 0; i < RANDOM_N; i++) pending_dates.push_back(random_date());

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_dates.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
